// ===== hdl/qtl_pkg.sv =====
// Shared types, constants and lookup functions for the quadtree tile LOD decision block.
// No dependencies; the top level and the testbench import this package.
`default_nettype none

package qtl_pkg;

	localparam int LEVELS_MAX_DEF = 6;

	// Fixed datapath widths that follow from the field formats.
	localparam int SQ_W    = 46;   // squared distance
	localparam int DIST_W  = 23;   // distance in Q.16
	localparam int DOT_W   = 41;   // view direction dot product
	localparam int PNUM_W  = 40;   // projection dividend
	localparam int PDEN_W  = 24;   // projection divisor
	localparam int MNUM_W  = 24;   // morph dividend
	localparam int MDEN_W  = 16;   // morph divisor

	localparam logic [23:0] DIST_BIAS = 24'd66;

	localparam logic [15:0] COS_MAX = 16'd32768;
	localparam logic [15:0] ERR_MIN = 16'd128;
	localparam logic [7:0]  HYS_MIN = 8'd128;
	localparam logic [7:0]  HYS_MAX = 8'd243;

	localparam logic [15:0] COS_RST   = 16'd23170;
	localparam logic [31:0] FOCAL_RST = 32'd65536;
	localparam logic [15:0] ERR_RST   = 16'd512;
	localparam logic [7:0]  HYS_RST   = 8'd204;
	localparam logic [2:0]  LOD_RST   = 3'd6;

	typedef enum logic [1:0] {
		VERDICT_CULL  = 2'd0,
		VERDICT_SPLIT = 2'd1,
		VERDICT_LEAF  = 2'd2
	} verdict_t;

	typedef enum logic [2:0] {
		CFG_CAM_POS  = 3'd0,
		CFG_CAM_FWD  = 3'd1,
		CFG_COS_FOV  = 3'd2,
		CFG_NEAR_FAR = 3'd3,
		CFG_FOCAL    = 3'd4,
		CFG_TARGET   = 3'd5,
		CFG_HYST     = 3'd6,
		CFG_MAX_LOD  = 3'd7
	} cfg_reg_t;

	// Bounding radius of a tile, size times 1/sqrt(2), rounded, in Q.16.
	function automatic logic [15:0] radius_of(input logic [2:0] lvl);
		logic [15:0] r;
		unique case (lvl)
			3'd0: r = 16'd46341;
			3'd1: r = 16'd23171;
			3'd2: r = 16'd11585;
			3'd3: r = 16'd5793;
			3'd4: r = 16'd2896;
			3'd5: r = 16'd1448;
			3'd6: r = 16'd724;
			3'd7: r = 16'd362;
		endcase
		return r;
	endfunction

	// First store entry of a level: the number of tiles on all shallower levels.
	function automatic logic [15:0] level_base(input logic [2:0] lvl);
		logic [15:0] b;
		unique case (lvl)
			3'd0: b = 16'd0;
			3'd1: b = 16'd1;
			3'd2: b = 16'd5;
			3'd3: b = 16'd21;
			3'd4: b = 16'd85;
			3'd5: b = 16'd341;
			3'd6: b = 16'd1365;
			3'd7: b = 16'd5461;
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/quadtree_tile_lod_decision.sv =====
// Quadtree terrain tile LOD decision: cull, projected size, split hysteresis and morph ramp.
// Depends on qtl_pkg, qtl_isqrt, qtl_div and qtl_marks.
`default_nettype none

// One tile item is accepted per clock while in_stall is low, and each gives exactly one
// result. The pipeline depth is set by the 23-stage square root, the 40-stage projection
// divider and the 24-stage morph divider, one bit per stage each. The split marks sit in a
// single-port-write memory that is read one stage before the decision and written back in
// the decision stage, with same-entry forwarding. After reset the mark memory is cleared
// one entry a cycle, (4^(LEVELS_MAX+1)-1)/3 entries (5461 by default), during which no item
// is accepted; configuration writes are taken throughout. A result that is not taken holds
// the pipeline only once a finished item reaches its end.
module quadtree_tile_lod_decision #(
	parameter int LEVELS_MAX = qtl_pkg::LEVELS_MAX_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [63:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  tile_level,
	input  wire logic [5:0]  tile_x,
	input  wire logic [5:0]  tile_y,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       verdict,
	output logic [8:0]       morph
);

	import qtl_pkg::*;

	localparam int DEPTH = ((1 << (2 * (LEVELS_MAX + 1))) - 1) / 3;
	localparam int AW    = $clog2(DEPTH);

	typedef struct packed {
		logic [2:0]       lvl;
		logic             in_store;
		logic [AW-1:0]    idx;
		logic [DOT_W-1:0] dot;
	} sq_tag_t;

	typedef struct packed {
		logic [2:0]    lvl;
		logic          in_store;
		logic [AW-1:0] idx;
		logic          culled;
	} pj_tag_t;

	typedef struct packed {
		verdict_t vd;
		logic     sat;
		logic     zero;
	} mo_tag_t;

	// Configuration registers.
	logic [59:0] cam_pos_q;
	logic [47:0] cam_fwd_q;
	logic [15:0] cos_q;
	logic [63:0] near_far_q;
	logic [31:0] focal_q;
	logic [15:0] err_q;
	logic [7:0]  hys_q;
	logic [2:0]  max_lod_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_pos_q  <= '0;
			cam_fwd_q  <= '0;
			cos_q      <= COS_RST;
			near_far_q <= '0;
			focal_q    <= FOCAL_RST;
			err_q      <= ERR_RST;
			hys_q      <= HYS_RST;
			max_lod_q  <= LOD_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_CAM_POS:  cam_pos_q  <= cfg_data[59:0];
				CFG_CAM_FWD:  cam_fwd_q  <= cfg_data[47:0];
				CFG_COS_FOV:  cos_q <= (cfg_data[15:0] > COS_MAX) ? COS_MAX : cfg_data[15:0];
				CFG_NEAR_FAR: near_far_q <= cfg_data;
				CFG_FOCAL:    focal_q    <= cfg_data[31:0];
				CFG_TARGET:   err_q <= (cfg_data[15:0] < ERR_MIN) ? ERR_MIN : cfg_data[15:0];
				CFG_HYST: begin
					if (cfg_data[7:0] < HYS_MIN) begin
						hys_q <= HYS_MIN;
					end else if (cfg_data[7:0] > HYS_MAX) begin
						hys_q <= HYS_MAX;
					end else begin
						hys_q <= cfg_data[7:0];
					end
				end
				CFG_MAX_LOD:  max_lod_q  <= cfg_data[2:0];
			endcase
		end
	end

	// Pipeline control: everything advances together unless a finished item is blocked.
	logic    en;
	logic    busy;
	logic    mo_vld;
	logic    out_valid_q;
	logic [1:0] verdict_q;
	logic [8:0] morph_q;

	assign en       = !(out_valid_q && out_stall && mo_vld);
	assign in_stall = busy || !en;

	// Stage 1: tile centre relative to the camera and store index.
	logic [22:0]        cx, cz;
	logic signed [23:0] vx, vy, vz;
	logic               in_store;
	logic [15:0]        idx_full;

	always_comb begin
		cx = 23'({tile_x, 1'b1, 16'b0}) >> ({1'b0, tile_level} + 4'd1);
		cz = 23'({tile_y, 1'b1, 16'b0}) >> ({1'b0, tile_level} + 4'd1);
		vx = $signed({1'b0, cx}) - 24'($signed(cam_pos_q[19:0]));
		vy = 24'sd0 - 24'($signed(cam_pos_q[39:20]));
		vz = $signed({1'b0, cz}) - 24'($signed(cam_pos_q[59:40]));
		in_store = ({29'b0, tile_level} <= LEVELS_MAX)
			&& ({2'b0, tile_x} < (8'd1 << tile_level))
			&& ({2'b0, tile_y} < (8'd1 << tile_level));
		idx_full = level_base(tile_level) + ({10'b0, tile_y} << tile_level) + {10'b0, tile_x};
	end

	logic               v_s1, v_s2, v_s3;
	logic signed [23:0] vx_s1, vy_s1, vz_s1;
	logic [2:0]         lvl_s1, lvl_s2, lvl_s3;
	logic               ins_s1, ins_s2, ins_s3;
	logic [AW-1:0]      idx_s1, idx_s2, idx_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			vx_s1  <= vx;
			vy_s1  <= vy;
			vz_s1  <= vz;
			lvl_s1 <= tile_level;
			ins_s1 <= in_store;
			idx_s1 <= AW'(idx_full);
		end
	end

	// Stage 2: squares and direction products.
	logic signed [47:0] sqx, sqy, sqz;
	logic signed [39:0] px, py, pz;

	assign sqx = vx_s1 * vx_s1;
	assign sqy = vy_s1 * vy_s1;
	assign sqz = vz_s1 * vz_s1;
	assign px  = vx_s1 * $signed(cam_fwd_q[15:0]);
	assign py  = vy_s1 * $signed(cam_fwd_q[31:16]);
	assign pz  = vz_s1 * $signed(cam_fwd_q[47:32]);

	logic [SQ_W-1:0]    sqx_s2, sqy_s2, sqz_s2;
	logic signed [39:0] px_s2, py_s2, pz_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s2 <= sqx[SQ_W-1:0];
			sqy_s2 <= sqy[SQ_W-1:0];
			sqz_s2 <= sqz[SQ_W-1:0];
			px_s2  <= px;
			py_s2  <= py;
			pz_s2  <= pz;
			lvl_s2 <= lvl_s1;
			ins_s2 <= ins_s1;
			idx_s2 <= idx_s1;
		end
	end

	// Stage 3: sums.
	logic [SQ_W-1:0]           sum_s3;
	logic signed [DOT_W-1:0]   dot_s3;
	logic signed [DOT_W-1:0]   dot_sum;

	assign dot_sum = px_s2 + py_s2 + pz_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s3 <= sqx_s2 + sqy_s2 + sqz_s2;
			dot_s3 <= dot_sum;
			lvl_s3 <= lvl_s2;
			ins_s3 <= ins_s2;
			idx_s3 <= idx_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Distance.
	sq_tag_t           sq_tag_in, sq_tag_out;
	logic              sq_vld;
	logic [DIST_W-1:0] cam_range;

	assign sq_tag_in = '{lvl: lvl_s3, in_store: ins_s3, idx: idx_s3, dot: dot_s3};

	qtl_isqrt #(
		.NW (SQ_W),
		.TW ($bits(sq_tag_t))
	) u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (v_s3),
		.rad_i  (sum_s3),
		.tag_i  (sq_tag_in),
		.vld_o  (sq_vld),
		.root_o (cam_range),
		.tag_o  (sq_tag_out)
	);

	// Stage 4: range test, cone product and divider operands.
	logic [15:0]       radius;
	logic              far_fail, near_fail;
	logic              v_s4, rcull_s4, ins_s4;
	logic [39:0]       cone_s4;
	logic [DOT_W-1:0]  dot_s4;
	logic [PDEN_W-1:0] den_s4;
	logic [PNUM_W-1:0] num_s4;
	logic [2:0]        lvl_s4;
	logic [AW-1:0]     idx_s4;

	assign radius    = radius_of(sq_tag_out.lvl);
	assign far_fail  = ($signed({11'b0, cam_range}) - $signed({18'b0, radius}))
		> $signed({2'b0, near_far_q[63:32]});
	assign near_fail = ({9'b0, cam_range} + {16'b0, radius}) < near_far_q[31:0];

	always_ff @(posedge clk) begin
		if (en) begin
			rcull_s4 <= far_fail || near_fail;
			cone_s4  <= cos_q * ({1'b0, cam_range} + 24'd1);
			dot_s4   <= sq_tag_out.dot;
			den_s4   <= {1'b0, cam_range} + DIST_BIAS;
			num_s4   <= {8'b0, focal_q} << (4'd8 - {1'b0, sq_tag_out.lvl});
			lvl_s4   <= sq_tag_out.lvl;
			ins_s4   <= sq_tag_out.in_store;
			idx_s4   <= sq_tag_out.idx;
		end
	end

	// Projected size.
	pj_tag_t           pj_tag_in, pj_tag_out;
	logic              pj_vld;
	logic [PNUM_W-1:0] proj;
	logic              cone_fail;

	// Twice the dot product against cosine times distance plus one, both in Q.31.
	assign cone_fail = $signed({dot_s4, 1'b0}) < $signed({2'b0, cone_s4});
	assign pj_tag_in = '{lvl: lvl_s4, in_store: ins_s4, idx: idx_s4,
		culled: rcull_s4 || cone_fail};

	qtl_div #(
		.NW (PNUM_W),
		.DW (PDEN_W),
		.TW ($bits(pj_tag_t))
	) u_pdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (v_s4),
		.num_i  (num_s4),
		.den_i  (den_s4),
		.tag_i  (pj_tag_in),
		.vld_o  (pj_vld),
		.quo_o  (proj),
		.tag_o  (pj_tag_out)
	);

	// Stage 5: thresholds and ramp numerator; the mark is read on the way in.
	logic [23:0] merge_lim;
	logic [41:0] p4, a3, diff;
	logic        mark;

	assign merge_lim = err_q * hys_q;
	assign p4   = {proj, 2'b0};
	assign a3   = ({26'b0, err_q} << 1) + {26'b0, err_q};
	assign diff = p4 - a3;

	logic          v_s5, culled_s5, ins_s5, wsplit_s5, wmerge_s5, zero_s5, sat_s5;
	logic [2:0]    lvl_s5;
	logic [AW-1:0] idx_s5;
	logic [16:0]   n_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			culled_s5 <= pj_tag_out.culled;
			ins_s5    <= pj_tag_out.in_store;
			lvl_s5    <= pj_tag_out.lvl;
			idx_s5    <= pj_tag_out.idx;
			wsplit_s5 <= proj > {24'b0, err_q};
			wmerge_s5 <= {proj, 8'b0} < {24'b0, merge_lim};
			zero_s5   <= p4 <= a3;
			sat_s5    <= diff >= ({26'b0, err_q} << 1);
			n_s5      <= diff[16:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s4 <= sq_vld;
			v_s5 <= pj_vld;
		end
	end

	logic     may_split, do_split, mk_we;
	verdict_t vd;

	assign may_split = lvl_s5 < max_lod_q;
	assign do_split  = !culled_s5 && may_split
		&& (wsplit_s5 || (!wmerge_s5 && ins_s5 && mark));
	assign mk_we     = en && v_s5 && !culled_s5 && may_split && ins_s5
		&& (wsplit_s5 || wmerge_s5);

	always_comb begin
		priority if (culled_s5) begin
			vd = VERDICT_CULL;
		end else if (do_split) begin
			vd = VERDICT_SPLIT;
		end else begin
			vd = VERDICT_LEAF;
		end
	end

	qtl_marks #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_marks (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (en),
		.rd_addr (pj_tag_out.idx),
		.rd_data (mark),
		.wr_en   (mk_we),
		.wr_addr (idx_s5),
		.wr_data (wsplit_s5),
		.busy    (busy)
	);

	// Morph ramp: (4*proj - 3*a) * 128 / a, below 256 whenever it is not saturated.
	mo_tag_t           mo_tag_in, mo_tag_out;
	logic [MNUM_W-1:0] mquo;

	assign mo_tag_in = '{vd: vd, sat: sat_s5, zero: zero_s5};

	qtl_div #(
		.NW (MNUM_W),
		.DW (MDEN_W),
		.TW ($bits(mo_tag_t))
	) u_mdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (v_s5),
		.num_i  ({n_s5, 7'b0}),
		.den_i  (err_q),
		.tag_i  (mo_tag_in),
		.vld_o  (mo_vld),
		.quo_o  (mquo),
		.tag_o  (mo_tag_out)
	);

	// Output register.
	always_ff @(posedge clk) begin
		if (en && mo_vld) begin
			verdict_q <= mo_tag_out.vd;
			if (mo_tag_out.vd != VERDICT_LEAF || mo_tag_out.zero) begin
				morph_q <= 9'd0;
			end else if (mo_tag_out.sat) begin
				morph_q <= 9'd256;
			end else begin
				morph_q <= {1'b0, mquo[7:0]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en && mo_vld) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign verdict   = verdict_q;
	assign morph     = morph_q;

endmodule

`default_nettype wire

// ===== hdl/qtl_isqrt.sv =====
// Pipelined integer square root, one result bit per stage, with a side tag.
// Stand-alone; used by the top level for the camera distance.
`default_nettype none

module qtl_isqrt #(
	parameter int NW = 46,
	parameter int TW = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          vld_i,
	input  wire logic [NW-1:0] rad_i,
	input  wire logic [TW-1:0] tag_i,
	output logic               vld_o,
	output logic [(NW+1)/2-1:0] root_o,
	output logic [TW-1:0]      tag_o
);

	localparam int RW = (NW + 1) / 2;
	localparam int W  = 2 * RW + 1;

	logic [RW-1:0] vld_s;
	logic [NW-1:0] rem_s  [RW];
	logic [RW-1:0] root_s [RW];
	logic [TW-1:0] tag_s  [RW];
	logic [NW-1:0] rem_nx [RW];
	logic [RW-1:0] root_nx[RW];

	// Stage k decides root bit RW-1-k from the remainder n - root^2.
	always_comb begin
		logic [NW-1:0] rin;
		logic [RW-1:0] qin;
		logic [W-1:0]  trial;
		int            bi;
		for (int k = 0; k < RW; k++) begin
			bi  = RW - 1 - k;
			rin = (k == 0) ? rad_i : rem_s[(k == 0) ? 0 : k - 1];
			qin = (k == 0) ? '0 : root_s[(k == 0) ? 0 : k - 1];
			trial = (W'(qin) << (bi + 1)) | (W'(1) << (2 * bi));
			if (W'(rin) >= trial) begin
				rem_nx[k]  = NW'(W'(rin) - trial);
				root_nx[k] = qin | (RW'(1) << bi);
			end else begin
				rem_nx[k]  = rin;
				root_nx[k] = qin;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s  <= rem_nx;
			root_s <= root_nx;
			tag_s[0] <= tag_i;
			for (int k = 1; k < RW; k++) begin
				tag_s[k] <= tag_s[k-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[RW-2:0], vld_i};
		end
	end

	assign vld_o  = vld_s[RW-1];
	assign root_o = root_s[RW-1];
	assign tag_o  = tag_s[RW-1];

endmodule

`default_nettype wire

// ===== hdl/qtl_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with a side tag.
// Stand-alone; used twice by the top level (projection and morph ramp).
`default_nettype none

module qtl_div #(
	parameter int NW = 40,
	parameter int DW = 24,
	parameter int TW = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          vld_i,
	input  wire logic [NW-1:0] num_i,
	input  wire logic [DW-1:0] den_i,
	input  wire logic [TW-1:0] tag_i,
	output logic               vld_o,
	output logic [NW-1:0]      quo_o,
	output logic [TW-1:0]      tag_o
);

	logic [NW-1:0] vld_s;
	logic [DW-1:0] rem_s [NW];
	// Dividend bits still to be consumed at the top, quotient bits shifted in below.
	logic [NW-1:0] nq_s  [NW];
	logic [DW-1:0] den_s [NW];
	logic [TW-1:0] tag_s [NW];
	logic [DW-1:0] rem_nx[NW];
	logic [NW-1:0] nq_nx [NW];

	always_comb begin
		logic [DW-1:0] rin;
		logic [NW-1:0] qin;
		logic [DW-1:0] din;
		logic [DW:0]   trial;
		logic          take;
		for (int k = 0; k < NW; k++) begin
			rin   = (k == 0) ? '0 : rem_s[(k == 0) ? 0 : k - 1];
			qin   = (k == 0) ? num_i : nq_s[(k == 0) ? 0 : k - 1];
			din   = (k == 0) ? den_i : den_s[(k == 0) ? 0 : k - 1];
			trial = {rin, qin[NW-1]};
			take  = trial >= {1'b0, din};
			rem_nx[k] = take ? DW'(trial - {1'b0, din}) : trial[DW-1:0];
			nq_nx[k]  = {qin[NW-2:0], take};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s <= rem_nx;
			nq_s  <= nq_nx;
			den_s[0] <= den_i;
			tag_s[0] <= tag_i;
			for (int k = 1; k < NW; k++) begin
				den_s[k] <= den_s[k-1];
				tag_s[k] <= tag_s[k-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[NW-2:0], vld_i};
		end
	end

	assign vld_o = vld_s[NW-1];
	assign quo_o = nq_s[NW-1];
	assign tag_o = tag_s[NW-1];

endmodule

`default_nettype wire

// ===== hdl/qtl_marks.sv =====
// Split mark store: one bit per tile in a synchronous memory, cleared by a sweep after reset.
// Stand-alone; the top level reads, decides and writes back one entry per item.
`default_nettype none

module qtl_marks #(
	parameter int DEPTH = 5461,
	parameter int AW    = 13
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output logic               rd_data,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic          wr_data,
	output logic               busy
);

	logic          mem [DEPTH];
	logic          rd_q;
	logic          busy_q;
	logic [AW-1:0] clr_q;

	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem[clr_q] <= 1'b0;
		end else if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		// A write to the entry being read in the same cycle is forwarded.
		if (rd_en) begin
			rd_q <= (wr_en && !busy_q && wr_addr == rd_addr) ? wr_data : mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			clr_q  <= '0;
		end else if (busy_q) begin
			if (clr_q == AW'(DEPTH - 1)) begin
				busy_q <= 1'b0;
			end
			clr_q <= clr_q + 1'b1;
		end
	end

	assign rd_data = rd_q;
	assign busy    = busy_q;

endmodule

`default_nettype wire

// ===== verif/quadtree_tile_lod_decision_tb.sv =====
// Self-checking testbench for the quadtree tile LOD decision block: a directed table, then
// random camera settings and tiles, checked against an in-bench predictor with split marks.
// Depends on qtl_pkg and the quadtree_tile_lod_decision RTL.
`default_nettype none

module quadtree_tile_lod_decision_tb;
	import qtl_pkg::*;

	localparam int STORE_SIZE = 5461;
	localparam int TAIL_CYCLES = 120;
	localparam longint CYCLE_LIMIT = 2000000;

	typedef struct {
		verdict_t   v;
		logic [8:0] m;
	} lod_result_t;

	typedef struct {
		bit         look_down;
		logic [2:0] lvl;
		logic [5:0] x;
		logic [5:0] y;
		bit         typed;
		verdict_t   v;
		logic [8:0] m;
	} tile_row_t;

	logic clk, arst_n;
	logic cfg_we;
	cfg_reg_t cfg_index;
	logic [63:0] cfg_data;
	logic in_valid, in_stall;
	logic [2:0] tile_level;
	logic [5:0] tile_x, tile_y;
	logic out_valid, out_stall;
	logic [1:0] verdict;
	logic [8:0] morph;

	quadtree_tile_lod_decision dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.tile_level(tile_level), .tile_x(tile_x), .tile_y(tile_y),
		.out_valid(out_valid), .out_stall(out_stall),
		.verdict(verdict), .morph(morph)
	);

	// Shadow of the camera registers and of the split marks.
	logic [59:0] sh_cam;
	logic [47:0] sh_fwd;
	logic [15:0] sh_cos;
	logic [63:0] sh_near_far;
	logic [31:0] sh_focal;
	logic [15:0] sh_target;
	logic [7:0]  sh_hyst;
	logic [2:0]  sh_max_lod;
	bit hot_marks [STORE_SIZE];

	lod_result_t pending_results[$];
	tile_row_t directed[$];
	int errors = 0;
	int tiles_sent = 0, results_seen = 0, splits_seen = 0, leaves_seen = 0, culls_seen = 0;
	longint cycles = 0;
	bit long_hold = 0;
	int burst_left = 0;

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic longint unsigned int_root(input longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else
				r >>= 1;
			b >>= 2;
		end
		return r;
	endfunction

	// Works out the verdict and morph of one tile and updates the split marks as the block does.
	function automatic lod_result_t decide_tile(input logic [2:0] lvl, input logic [5:0] x,
			input logic [5:0] y);
		lod_result_t res;
		longint size, cx, cz, vx, vy, vz, cam_range, radius, dot_fv, nearv, farv;
		longint unsigned proj, a, p4, a3;
		bit in_store, mark, split;
		int idx;
		size = 65536 >> lvl;
		cx = ((2 * longint'(x) + 1) << 16) >> (lvl + 1);
		cz = ((2 * longint'(y) + 1) << 16) >> (lvl + 1);
		vx = cx - longint'($signed(sh_cam[19:0]));
		vy = -longint'($signed(sh_cam[39:20]));
		vz = cz - longint'($signed(sh_cam[59:40]));
		cam_range = longint'(int_root(longint'(vx * vx + vy * vy + vz * vz)));
		radius = (size * 46341 + 32768) >> 16;
		nearv = longint'(sh_near_far[31:0]);
		farv = longint'(sh_near_far[63:32]);
		dot_fv = vx * longint'($signed(sh_fwd[15:0])) + vy * longint'($signed(sh_fwd[31:16]))
			+ vz * longint'($signed(sh_fwd[47:32]));
		res.v = VERDICT_CULL;
		res.m = '0;
		if (cam_range - radius > farv || cam_range + radius < nearv
				|| dot_fv * 2 < longint'(sh_cos) * (cam_range + 1))
			return res;
		proj = (longint'(sh_focal) * size) / ((cam_range + 66) << 8);
		a = sh_target;
		in_store = lvl <= 6 && x < (1 << lvl) && y < (1 << lvl);
		idx = 0;
		mark = 0;
		if (in_store) begin
			idx = ((1 << (2 * lvl)) - 1) / 3 + y * (1 << lvl) + x;
			mark = hot_marks[idx];
		end
		split = 0;
		if (lvl < sh_max_lod) begin
			if (proj > a) begin
				split = 1;
				if (in_store) hot_marks[idx] = 1;
			end else if (proj * 256 < a * sh_hyst) begin
				if (in_store) hot_marks[idx] = 0;
			end else
				split = mark;
		end
		if (split) begin
			res.v = VERDICT_SPLIT;
			return res;
		end
		res.v = VERDICT_LEAF;
		p4 = proj * 4;
		a3 = a * 3;
		if (p4 <= a3) res.m = 0;
		else if (p4 - a3 >= 2 * a) res.m = 256;
		else res.m = 9'(((p4 - a3) * 128) / a);
		return res;
	endfunction

	// Each write lowers the enable again before the task returns, so back-to-back writes stay apart.
	task automatic write_reg(input cfg_reg_t idx, input logic [63:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		@(posedge clk);
		case (idx)
			CFG_CAM_POS:  sh_cam = val[59:0];
			CFG_CAM_FWD:  sh_fwd = val[47:0];
			CFG_COS_FOV:  sh_cos = (val[15:0] > COS_MAX) ? COS_MAX : val[15:0];
			CFG_NEAR_FAR: sh_near_far = val;
			CFG_FOCAL:    sh_focal = val[31:0];
			CFG_TARGET:   sh_target = (val[15:0] < ERR_MIN) ? ERR_MIN : val[15:0];
			CFG_HYST:     sh_hyst = (val[7:0] < HYS_MIN) ? HYS_MIN :
				(val[7:0] > HYS_MAX) ? HYS_MAX : val[7:0];
			CFG_MAX_LOD:  sh_max_lod = val[2:0];
		endcase
	endtask

	// Config may only change once the pipeline has drained.
	task automatic wait_drained();
		while (pending_results.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// The sender offers one item and holds it until taken; bursts end in a random gap.
	task automatic send_tile(input logic [2:0] lvl, input logic [5:0] x, input logic [5:0] y,
			output lod_result_t res);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				in_valid <= 0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 8);
		end
		in_valid <= 1;
		tile_level <= lvl;
		tile_x <= x;
		tile_y <= y;
		do @(posedge clk); while (in_stall);
		burst_left--;
		res = decide_tile(lvl, x, y);
		pending_results.insert(pending_results.size(), res);
		tiles_sent++;
	endtask

	task automatic look_down_setup();
		write_reg(CFG_CAM_POS, {20'sd32768, 20'sd65536, 20'sd32768});
		write_reg(CFG_CAM_FWD, {16'sd0, -16'sd16384, 16'sd0});
		write_reg(CFG_COS_FOV, 64'd16384);
		write_reg(CFG_NEAR_FAR, {32'h0010_0000, 32'd0});
		write_reg(CFG_FOCAL, 64'd400 << 16);
		write_reg(CFG_TARGET, 64'd8 << 8);
		write_reg(CFG_HYST, 64'd204);
		write_reg(CFG_MAX_LOD, 64'd6);
	endtask

	// Camera mostly above the square looking downward, with thresholds near the projected size.
	task automatic random_setup(input int phase);
		logic [19:0] px, py, pz;
		logic [15:0] fx, fy, fz;
		px = 20'($signed($urandom_range(0, 2 * 65536)) - 32768);
		pz = 20'($signed($urandom_range(0, 2 * 65536)) - 32768);
		py = 20'($urandom_range(1000, 200000));
		fx = 16'($signed($urandom_range(0, 12000)) - 6000);
		fz = 16'($signed($urandom_range(0, 12000)) - 6000);
		fy = 16'(-$signed($urandom_range(8000, 16384)));
		if (phase % 4 == 3) begin
			write_reg(CFG_CAM_POS, {$urandom, $urandom});
			write_reg(CFG_CAM_FWD, {$urandom, $urandom});
		end else begin
			write_reg(CFG_CAM_POS, {pz, py, px});
			write_reg(CFG_CAM_FWD, {fz, fy, fx});
		end
		write_reg(CFG_COS_FOV, ($urandom_range(0, 7) == 0) ? 64'($urandom)
			: 64'($urandom_range(0, 30000)));
		write_reg(CFG_NEAR_FAR, ($urandom_range(0, 4) == 0) ? {$urandom, $urandom}
			: {32'($urandom_range(65536, 600000)), 32'($urandom_range(0, 20000))});
		write_reg(CFG_FOCAL, 64'($urandom_range(100, 3000)) << $urandom_range(10, 16));
		write_reg(CFG_TARGET, ($urandom_range(0, 5) == 0) ? 64'($urandom)
			: 64'($urandom_range(64, 8000)));
		write_reg(CFG_HYST, 64'($urandom_range(0, 255)));
		write_reg(CFG_MAX_LOD, 64'($urandom_range(0, 7)));
	endtask

	always @(posedge clk) begin
		lod_result_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				$error("result with nothing expected: verdict %0d morph %0d", verdict, morph);
				errors++;
			end else begin
				exp_r = pending_results.pop_front();
				if (verdict !== exp_r.v) begin
					$error("verdict: expected %0d, actual %0d", exp_r.v, verdict);
					errors++;
				end
				if (morph !== exp_r.m) begin
					$error("morph: expected %0d, actual %0d", exp_r.m, morph);
					errors++;
				end
				case (exp_r.v)
					VERDICT_SPLIT: splits_seen++;
					VERDICT_LEAF:  leaves_seen++;
					default:       culls_seen++;
				endcase
			end
		end
	end

	// Receiver stalls on its own pattern, with stall-free stretches and one long hold-off.
	always @(posedge clk) begin
		int mode_left, hold_left, mode;
		if (!arst_n) begin
			mode_left = 0;
			hold_left = 0;
			mode = 0;
			out_stall <= 0;
		end else if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1;
		end else if (long_hold) begin
			long_hold = 0;
			hold_left = 400;
			out_stall <= 1;
		end else begin
			if (mode_left == 0) begin
				mode = $urandom_range(0, 2);
				mode_left = $urandom_range(20, 200);
			end
			mode_left--;
			case (mode)
				0: out_stall <= 0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				default: out_stall <= ($urandom_range(0, 1) == 0);
			endcase
		end
	end

	initial begin
		lod_result_t res;
		tile_row_t row;
		logic [2:0] lvl;
		logic [5:0] x, y;
		logic [5:0] pool_l [16];
		logic [5:0] pool_x [16];
		logic [5:0] pool_y [16];
		int k;
		arst_n = 0;
		cfg_we = 0;
		cfg_index = CFG_CAM_POS;
		cfg_data = '0;
		in_valid = 0;
		tile_level = '0;
		tile_x = '0;
		tile_y = '0;
		sh_cam = '0;
		sh_fwd = '0;
		sh_cos = COS_RST;
		sh_near_far = '0;
		sh_focal = FOCAL_RST;
		sh_target = ERR_RST;
		sh_hyst = HYS_RST;
		sh_max_lod = LOD_RST;
		foreach (hot_marks[i]) hot_marks[i] = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// After reset the camera faces nowhere, so every tile is culled.
		directed = '{
			'{0, 3'd0, 6'd0,  6'd0,  1, VERDICT_CULL, 9'd0},
			'{0, 3'd6, 6'd63, 6'd63, 1, VERDICT_CULL, 9'd0},
			'{0, 3'd7, 6'd0,  6'd0,  1, VERDICT_CULL, 9'd0},
			'{0, 3'd3, 6'd7,  6'd7,  1, VERDICT_CULL, 9'd0},
			'{0, 3'd7, 6'd63, 6'd63, 1, VERDICT_CULL, 9'd0},
			'{1, 3'd0, 6'd0,  6'd0,  0, VERDICT_CULL, 9'd0},
			'{1, 3'd0, 6'd0,  6'd0,  0, VERDICT_CULL, 9'd0},
			'{1, 3'd1, 6'd1,  6'd1,  0, VERDICT_CULL, 9'd0},
			'{1, 3'd2, 6'd3,  6'd0,  0, VERDICT_CULL, 9'd0},
			'{1, 3'd3, 6'd4,  6'd3,  0, VERDICT_CULL, 9'd0},
			'{1, 3'd4, 6'd8,  6'd8,  0, VERDICT_CULL, 9'd0},
			'{1, 3'd5, 6'd31, 6'd0,  0, VERDICT_CULL, 9'd0},
			'{1, 3'd6, 6'd0,  6'd0,  0, VERDICT_CULL, 9'd0},
			'{1, 3'd6, 6'd63, 6'd63, 0, VERDICT_CULL, 9'd0},
			'{1, 3'd6, 6'd32, 6'd31, 0, VERDICT_CULL, 9'd0},
			'{1, 3'd7, 6'd5,  6'd5,  0, VERDICT_CULL, 9'd0},
			'{1, 3'd3, 6'd9,  6'd2,  0, VERDICT_CULL, 9'd0},
			'{1, 3'd1, 6'd63, 6'd0,  0, VERDICT_CULL, 9'd0},
			'{1, 3'd2, 6'd1,  6'd2,  0, VERDICT_CULL, 9'd0},
			'{1, 3'd2, 6'd1,  6'd2,  0, VERDICT_CULL, 9'd0}
		};
		foreach (directed[i]) begin
			row = directed[i];
			if (row.look_down && (i == 0 || !directed[i - 1].look_down)) begin
				in_valid <= 0;
				burst_left = 0;
				wait_drained();
				look_down_setup();
			end
			send_tile(row.lvl, row.x, row.y, res);
			// Rows with a typed result must agree with the predictor before the block is checked.
			if (row.typed && (res.v !== row.v || res.m !== row.m)) begin
				$error("verdict/morph table: expected %0d/%0d, predicted %0d/%0d",
					row.v, row.m, res.v, res.m);
				errors++;
			end
		end
		in_valid <= 0;
		burst_left = 0;

		for (int phase = 0; phase < 12; phase++) begin
			wait_drained();
			if (phase == 0) begin
				// Extremes, each beyond its saturation point where the register has one.
				write_reg(CFG_COS_FOV, 64'hFFFF);
				write_reg(CFG_TARGET, 64'd0);
				write_reg(CFG_HYST, 64'd0);
				write_reg(CFG_MAX_LOD, 64'd7);
				write_reg(CFG_FOCAL, 64'hFFFF_FFFF);
				write_reg(CFG_NEAR_FAR, '1);
			end else if (phase == 1) begin
				look_down_setup();
				write_reg(CFG_COS_FOV, 64'd0);
				write_reg(CFG_HYST, 64'hFF);
				write_reg(CFG_TARGET, 64'hFFFF);
				write_reg(CFG_MAX_LOD, 64'd0);
				write_reg(CFG_FOCAL, 64'd0);
			end else
				random_setup(phase);
			for (int j = 0; j < 16; j++) begin
				pool_l[j] = 6'($urandom_range(0, 6));
				pool_x[j] = 6'($urandom_range(0, (1 << pool_l[j]) - 1));
				pool_y[j] = 6'($urandom_range(0, (1 << pool_l[j]) - 1));
			end
			for (int n = 0; n < 132; n++) begin
				if (phase == 4 && n == 10) long_hold = 1;
				k = $urandom_range(0, 9);
				if (k < 5) begin
					lvl = pool_l[k * 3 % 16 + n % 3][2:0];
					x = pool_x[k * 3 % 16 + n % 3];
					y = pool_y[k * 3 % 16 + n % 3];
				end else if (k < 8) begin
					lvl = 3'($urandom_range(0, 6));
					x = 6'($urandom_range(0, (1 << lvl) - 1));
					y = 6'($urandom_range(0, (1 << lvl) - 1));
				end else begin
					lvl = 3'($urandom);
					x = 6'($urandom);
					y = 6'($urandom);
				end
				send_tile(lvl, x, y, res);
			end
			in_valid <= 0;
			burst_left = 0;
		end

		while (pending_results.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Covered %0d tiles over 12 camera settings: %0d split, %0d leaf, %0d culled.",
			tiles_sent, splits_seen, leaves_seen, culls_seen);
		if (errors == 0 && pending_results.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

`default_nettype wire
